### rtl/core/wqpa_pkg.sv
// ----------------------------------------------------------------------------
// wqpa_pkg
// Types and constants shared by the weighted queue pair arbiter core.
// ----------------------------------------------------------------------------
package wqpa_pkg;

   localparam int NUM_QUEUES_DEF  = 16;
   localparam int PRIO_LEVELS_DEF = 3;
   localparam int SIZE_W  = 17;
   localparam int COUNT_W = 16;
   localparam int CQ_W    = 4;
   localparam int SQ_W    = 4;
   localparam int KIND_W  = 3;
   localparam int PRIO_W  = 2;
   localparam int VP_W    = 5;
   // weight * size fits in 19 bits
   localparam int PROD_W  = SIZE_W + 2;

   localparam logic [KIND_W-1:0] KIND_ADD_CQ   = 3'd0;
   localparam logic [KIND_W-1:0] KIND_ADD_SQ   = 3'd1;
   localparam logic [KIND_W-1:0] KIND_DEL_CQ   = 3'd2;
   localparam logic [KIND_W-1:0] KIND_DEL_SQ   = 3'd3;
   localparam logic [KIND_W-1:0] KIND_SERVE    = 3'd4;
   localparam logic [KIND_W-1:0] KIND_RST_CNT  = 3'd5;

   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic [SQ_W-1:0]   sq_id;
      logic [CQ_W-1:0]   cq_id;
      logic [SIZE_W-1:0] queue_size;
      logic [PRIO_W-1:0] priority_req;
   } req_type;

   typedef struct packed {
      logic            ok;
      logic [SQ_W-1:0] served_sq;
      logic [CQ_W-1:0] served_cq;
      logic [VP_W-1:0] valid_pairs;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DIV,
      ST_WALK,
      ST_DONE
   } state_type;

endpackage

### rtl/core/weighted_queue_pair_arbiter_core.sv
// ----------------------------------------------------------------------------
// weighted_queue_pair_arbiter_core
// Queue pair table with weighted serve-next arbitration.
// ----------------------------------------------------------------------------
// One transaction at a time. Table commands other than del_cq, reset_counts
// and serve_next go straight to the done state; del_cq and reset_counts walk
// the table, one entry per cycle. serve_next visits each entry in turn and,
// for each valid pair, runs one shared restoring divider, one quotient bit
// per cycle. The next request is taken while a response still waits; that
// command then holds in its last cycle until the response register frees
// up.
module weighted_queue_pair_arbiter_core #(
   parameter int NUM_QUEUES  = wqpa_pkg::NUM_QUEUES_DEF,
   parameter int PRIO_LEVELS = wqpa_pkg::PRIO_LEVELS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  wqpa_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output wqpa_pkg::rsp_type rsp_data
);

   localparam int IDX_W = $clog2(NUM_QUEUES);
   localparam int PW    = wqpa_pkg::PROD_W;
   localparam int DCW   = $clog2(PW + 1);

   // per-entry stores
   logic [NUM_QUEUES-1:0] present_ff, present_in;
   logic [NUM_QUEUES-1:0] pvalid_ff, pvalid_in;
   logic [wqpa_pkg::CQ_W:0]       bound_ff [NUM_QUEUES];
   logic [wqpa_pkg::SIZE_W-1:0]   size_ff  [NUM_QUEUES];
   logic [wqpa_pkg::PRIO_W-1:0]   prio_ff  [NUM_QUEUES];
   logic [wqpa_pkg::COUNT_W-1:0]  count_ff [NUM_QUEUES];

   logic                         pend_ff, pend_in;
   logic [wqpa_pkg::CQ_W-1:0]    pcq_ff, pcq_in;

   wqpa_pkg::state_type state_ff, state_in;
   wqpa_pkg::req_type   req_ff;
   logic [IDX_W-1:0]    idx_ff, idx_in;
   logic                ok_ff, ok_in;
   logic                found_ff, found_in;
   logic [IDX_W-1:0]    pick_ff, pick_in;
   logic [PW-1:0]       best_ff, best_in;

   // shared divider
   logic [PW-1:0]       quo_ff, quo_in;
   logic [wqpa_pkg::COUNT_W:0] rem_ff, rem_in;
   logic [wqpa_pkg::COUNT_W-1:0] div_ff, div_in;
   logic [DCW-1:0]      dcnt_ff, dcnt_in;

   logic                rsp_valid_ff, rsp_valid_in;
   wqpa_pkg::rsp_type   rsp_ff, rsp_in;

   logic [wqpa_pkg::VP_W-1:0] vcount;
   logic [1:0]          weight;
   logic [PW-1:0]       product;
   logic [wqpa_pkg::COUNT_W:0] rem_try;
   logic                sq_in_range;
   logic                last_idx;
   logic                entry_live;
   logic                rsp_free;
   logic                cnt_wr;
   logic [IDX_W-1:0]    cnt_wr_idx;
   logic [wqpa_pkg::COUNT_W-1:0] cnt_wr_val;

   always_comb begin
      vcount = '0;
      for (int i = 0; i < NUM_QUEUES; i++) begin
         vcount = vcount + wqpa_pkg::VP_W'(present_in[i] & pvalid_in[i]);
      end
   end

   assign sq_in_range = (int'(req_ff.sq_id) < NUM_QUEUES);
   assign last_idx    = (idx_ff == IDX_W'(NUM_QUEUES - 1));
   assign entry_live  = present_ff[idx_ff] & pvalid_ff[idx_ff];
   assign weight      = ({1'b0, prio_ff[idx_ff]} >= 3'(PRIO_LEVELS)) ? 2'd0 :
                        2'(PRIO_LEVELS - int'(prio_ff[idx_ff]));
   assign product     = PW'(weight) * PW'(size_ff[idx_ff]);
   assign rem_try     = {rem_ff[wqpa_pkg::COUNT_W-1:0], quo_ff[PW-1]}
                        - {1'b0, div_ff};
   assign rsp_free    = !rsp_valid_ff || rsp_ready;
   assign req_ready   = (state_ff == wqpa_pkg::ST_IDLE);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         wqpa_pkg::ST_IDLE: if (req_valid && req_ready) begin
            priority if (req_data.kind == wqpa_pkg::KIND_DEL_CQ ||
                         req_data.kind == wqpa_pkg::KIND_RST_CNT ||
                         req_data.kind == wqpa_pkg::KIND_SERVE)
               state_in = wqpa_pkg::ST_SCAN;
            else
               state_in = wqpa_pkg::ST_DONE;
         end
         wqpa_pkg::ST_SCAN: begin
            if (req_ff.kind == wqpa_pkg::KIND_SERVE) begin
               state_in = wqpa_pkg::ST_WALK;
            end else if (last_idx) begin
               state_in = wqpa_pkg::ST_DONE;
            end
         end
         wqpa_pkg::ST_WALK: begin
            if (entry_live) state_in = wqpa_pkg::ST_DIV;
            else if (last_idx) state_in = wqpa_pkg::ST_DONE;
         end
         wqpa_pkg::ST_DIV: begin
            if (dcnt_ff == DCW'(1)) begin
               state_in = last_idx ? wqpa_pkg::ST_DONE : wqpa_pkg::ST_WALK;
            end
         end
         wqpa_pkg::ST_DONE: if (rsp_free) state_in = wqpa_pkg::ST_IDLE;
         default: state_in = wqpa_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      idx_in = idx_ff;  ok_in = ok_ff;  found_in = found_ff;
      pick_in = pick_ff; best_in = best_ff;
      quo_in = quo_ff;  rem_in = rem_ff;  div_in = div_ff;  dcnt_in = dcnt_ff;
      present_in = present_ff; pvalid_in = pvalid_ff;
      pend_in = pend_ff; pcq_in = pcq_ff;
      cnt_wr = 1'b0; cnt_wr_idx = idx_ff; cnt_wr_val = '0;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_in = rsp_ff;
      unique case (state_ff)
         wqpa_pkg::ST_IDLE: begin
            idx_in = '0; ok_in = 1'b0; found_in = 1'b0;
            pick_in = '0; best_in = '0;
         end
         wqpa_pkg::ST_SCAN: begin
            if (req_ff.kind == wqpa_pkg::KIND_DEL_CQ) begin
               if (present_ff[idx_ff] && bound_ff[idx_ff] == {1'b0, req_ff.cq_id}) begin
                  pvalid_in[idx_ff] = 1'b0;
                  cnt_wr = 1'b1;
                  ok_in = 1'b1;
               end
               idx_in = idx_ff + IDX_W'(1);
            end else if (req_ff.kind == wqpa_pkg::KIND_RST_CNT) begin
               ok_in = 1'b1;
               cnt_wr = present_ff[idx_ff];
               idx_in = idx_ff + IDX_W'(1);
            end
         end
         wqpa_pkg::ST_WALK: begin
            if (entry_live) begin
               quo_in  = product;
               rem_in  = '0;
               div_in  = (count_ff[idx_ff] == '0) ? wqpa_pkg::COUNT_W'(1) : count_ff[idx_ff];
               dcnt_in = DCW'(PW);
            end else begin
               idx_in = idx_ff + IDX_W'(1);
            end
         end
         wqpa_pkg::ST_DIV: begin
            // restoring division, one quotient bit per cycle
            if (!rem_try[wqpa_pkg::COUNT_W]) begin
               rem_in = rem_try;
               quo_in = {quo_ff[PW-2:0], 1'b1};
            end else begin
               rem_in = {rem_ff[wqpa_pkg::COUNT_W-1:0], quo_ff[PW-1]};
               quo_in = {quo_ff[PW-2:0], 1'b0};
            end
            dcnt_in = dcnt_ff - DCW'(1);
            if (dcnt_ff == DCW'(1)) begin
               if (quo_in > best_ff) begin
                  best_in = quo_in; pick_in = idx_ff; found_in = 1'b1;
               end
               idx_in = idx_ff + IDX_W'(1);
            end
         end
         wqpa_pkg::ST_DONE: if (rsp_free) begin
            priority case (req_ff.kind)
               wqpa_pkg::KIND_ADD_CQ: if (!pend_ff) begin
                  pend_in = 1'b1; pcq_in = req_ff.cq_id; ok_in = 1'b1;
               end
               wqpa_pkg::KIND_ADD_SQ:
                  if (pend_ff && req_ff.cq_id == pcq_ff && sq_in_range) begin
                     if (!present_ff[IDX_W'(req_ff.sq_id)]) begin
                        present_in[IDX_W'(req_ff.sq_id)] = 1'b1;
                        pvalid_in[IDX_W'(req_ff.sq_id)]  = 1'b1;
                        cnt_wr = 1'b1;
                        cnt_wr_idx = IDX_W'(req_ff.sq_id);
                     end
                     pend_in = 1'b0; pcq_in = '0; ok_in = 1'b1;
                  end
               wqpa_pkg::KIND_DEL_SQ:
                  if (sq_in_range && present_ff[IDX_W'(req_ff.sq_id)] &&
                      !pvalid_ff[IDX_W'(req_ff.sq_id)]) begin
                     present_in[IDX_W'(req_ff.sq_id)] = 1'b0;
                     ok_in = 1'b1;
                  end
               wqpa_pkg::KIND_SERVE: if (found_ff) begin
                  cnt_wr = 1'b1;
                  cnt_wr_idx = pick_ff;
                  cnt_wr_val = count_ff[pick_ff] + wqpa_pkg::COUNT_W'(1);
                  ok_in = 1'b1;
               end
               default: ;
            endcase
            rsp_valid_in = 1'b1;
            rsp_in.ok = ok_in;
            rsp_in.served_sq = (req_ff.kind == wqpa_pkg::KIND_SERVE && found_ff) ?
                               wqpa_pkg::SQ_W'(pick_ff) : '0;
            rsp_in.served_cq = (req_ff.kind == wqpa_pkg::KIND_SERVE && found_ff) ?
                               bound_ff[pick_ff][wqpa_pkg::CQ_W-1:0] : '0;
            rsp_in.valid_pairs = vcount;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= wqpa_pkg::ST_IDLE;
         present_ff <= '0; pvalid_ff <= '0;
         pend_ff <= 1'b0; pcq_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         present_ff <= present_in; pvalid_ff <= pvalid_in;
         pend_ff <= pend_in; pcq_ff <= pcq_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) req_ff <= req_data;
      idx_ff <= idx_in; ok_ff <= ok_in; found_ff <= found_in;
      pick_ff <= pick_in; best_ff <= best_in;
      quo_ff <= quo_in; rem_ff <= rem_in; div_ff <= div_in; dcnt_ff <= dcnt_in;
      rsp_ff <= rsp_in;
      if (cnt_wr) count_ff[cnt_wr_idx] <= cnt_wr_val;
      if (state_ff == wqpa_pkg::ST_SCAN && req_ff.kind == wqpa_pkg::KIND_DEL_CQ &&
          present_ff[idx_ff] && bound_ff[idx_ff] == {1'b0, req_ff.cq_id})
         bound_ff[idx_ff] <= (wqpa_pkg::CQ_W + 1)'(16);
      if (state_ff == wqpa_pkg::ST_DONE && rsp_free &&
          req_ff.kind == wqpa_pkg::KIND_ADD_SQ &&
          pend_ff && req_ff.cq_id == pcq_ff && sq_in_range &&
          !present_ff[IDX_W'(req_ff.sq_id)]) begin
         bound_ff[IDX_W'(req_ff.sq_id)] <= {1'b0, req_ff.cq_id};
         size_ff[IDX_W'(req_ff.sq_id)]  <= req_ff.queue_size;
         prio_ff[IDX_W'(req_ff.sq_id)]  <= req_ff.priority_req;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   a_busy_not_ready: assert property (@(posedge clock) disable iff (reset)
      state_ff != wqpa_pkg::ST_IDLE |-> !req_ready) else $error("ready while busy");
   a_pend_cq_zero: assert property (@(posedge clock) disable iff (reset)
      !pend_ff |-> pcq_ff == '0) else $error("stale pending cq");
   a_valid_present: assert property (@(posedge clock) disable iff (reset)
      (pvalid_ff & ~present_ff) == '0) else $error("valid pair not present");
   a_serve_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_ff.ok |-> rsp_ff.served_sq == '0)
      else $error("served id without ok");

endmodule
